// ===== design/psct_pkg.sv =====
// Shared constants, codes and control types for the primitive set collision test.
package psct_pkg;

	// Default sizes
	localparam int MaxPrims   = 16;
	localparam int CoordWidth = 32;

	// Fixed field widths and divide step count
	localparam int ExtW      = 30;
	localparam int NormW     = 18;
	localparam int QuotSteps = 18;

	// Operation codes
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_LOAD_A = 2'd1;
	localparam logic [1:0] OP_LOAD_B = 2'd2;
	localparam logic [1:0] OP_QUERY  = 2'd3;

	// Shape codes
	localparam logic [1:0] SHAPE_NONE   = 2'd0;
	localparam logic [1:0] SHAPE_SPHERE = 2'd1;
	localparam logic [1:0] SHAPE_BOX    = 2'd2;

	// Root and divide unit control and status
	typedef struct packed {
		logic start;
		logic is_div;
	} rd_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rd_stat_t;

endpackage

// ===== design/psct_if.sv =====
// Request and response channel interfaces of the primitive set collision test.
interface psct_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        opcode;
	logic [1:0]        shape;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic [29:0]       extent_x;
	logic [29:0]       extent_y;
	logic [29:0]       extent_z;

	modport source (output valid, opcode, shape, pos_x, pos_y, pos_z,
		extent_x, extent_y, extent_z, input ready);
	modport sink (input valid, opcode, shape, pos_x, pos_y, pos_z,
		extent_x, extent_y, extent_z, output ready);
endinterface

interface psct_rsp_if;
	logic               valid;
	logic               ready;
	logic               any_overlap;
	logic               contact_found;
	logic [3:0]         index_a;
	logic [3:0]         index_b;
	logic signed [17:0] normal_x;
	logic signed [17:0] normal_y;
	logic signed [17:0] normal_z;
	logic [30:0]        depth;
	logic signed [31:0] contact_x;
	logic signed [31:0] contact_y;
	logic signed [31:0] contact_z;

	modport source (output valid, any_overlap, contact_found, index_a, index_b,
		normal_x, normal_y, normal_z, depth, contact_x, contact_y, contact_z,
		input ready);
	modport sink (input valid, any_overlap, contact_found, index_a, index_b,
		normal_x, normal_y, normal_z, depth, contact_x, contact_y, contact_z,
		output ready);
endinterface

// ===== design/psct_rootdiv.sv =====
// Bit-serial square root and normal divider sharing one compare and subtract.
module psct_rootdiv #(
	parameter int RW = 34
) (
	input  logic                clk,
	input  logic                arst_n,
	input  psct_pkg::rd_ctrl_t  ctrl,
	input  logic [2*RW-1:0]     radicand,
	input  logic [RW-2:0]       dividend,
	input  logic [RW-1:0]       divisor,
	output psct_pkg::rd_stat_t  stat,
	output logic [RW-1:0]       result
);
	import psct_pkg::*;

	localparam int SW   = 2 * RW;
	localparam int REMW = RW + 17;
	localparam int CNTW = $clog2(RW + 1);

	logic            busy_q, done_q, mode_q;
	logic [CNTW-1:0] cnt_q;
	logic [REMW-1:0] rem_q;
	logic [SW-1:0]   aux_q;
	logic [RW-1:0]   root_q;

	logic [REMW-1:0] sq_rem, sq_trial, op_a, op_b;
	logic [REMW:0]   diff;
	logic            take;

	// Shared trial subtraction: root digit or quotient bit
	always_comb begin
		sq_rem   = {rem_q[REMW-3:0], aux_q[SW-1:SW-2]};
		sq_trial = {{(REMW-RW-2){1'b0}}, root_q, 2'b01};
		op_a     = mode_q ? rem_q : sq_rem;
		op_b     = mode_q ? aux_q[REMW-1:0] : sq_trial;
		diff     = {1'b0, op_a} - {1'b0, op_b};
		take     = !diff[REMW];
	end

	// Step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			mode_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start && !busy_q) begin
				busy_q <= 1'b1;
				mode_q <= ctrl.is_div;
				cnt_q  <= ctrl.is_div ? CNTW'(QuotSteps) : CNTW'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (ctrl.start && !busy_q) begin
			root_q <= '0;
			if (ctrl.is_div) begin
				rem_q <= {2'b00, dividend, 16'd0};
				aux_q <= {{(SW-REMW){1'b0}}, divisor, 17'd0};
			end else begin
				rem_q <= '0;
				aux_q <= radicand;
			end
		end else if (busy_q) begin
			rem_q  <= take ? diff[REMW-1:0] : op_a;
			root_q <= {root_q[RW-2:0], take};
			aux_q  <= mode_q ? (aux_q >> 1) : (aux_q << 2);
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result    = root_q;

`ifndef ASSERT_OFF
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("done while still busy");
	a_cnt_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0) else $error("busy with no steps left");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("done held over two cycles");
`endif

endmodule

// ===== design/primitive_set_collision_test_top.sv =====
// Primitive set collision test: shape stores, pair scan sequencer and contact maths.
// Clear and load items complete in the idle state. A query fetches, classifies and steps
// past each pair; a sphere pair loads and multiplies four terms digit by digit (ND = 16-bit
// digits of the shared multiplier, 3 at 32-bit coordinates), and a box pair tests up to 3
// axes; the first sphere contact adds a bit-serial root and one 18-step divide per axis
// and ends the scan. One item at a time; a finished result waits in an output register.
// Reset clears the set counts and the sequencer; shape stores are not cleared.
module primitive_set_collision_test_top #(
	parameter int MAX_PRIMS   = psct_pkg::MaxPrims,
	parameter int COORD_WIDTH = psct_pkg::CoordWidth
) (
	input  logic       clk,
	input  logic       arst_n,
	psct_req_if.sink   req,
	psct_rsp_if.source rsp
);
	import psct_pkg::*;

	localparam int IW    = (MAX_PRIMS > 1) ? $clog2(MAX_PRIMS) : 1;
	localparam int CNTW  = IW + 1;
	localparam int CW    = COORD_WIDTH;
	localparam int OW    = (CW + 1 > 31) ? CW + 1 : 31;
	localparam int RW    = OW + 1;
	localparam int SW    = 2 * RW;
	localparam int ACCW  = SW + 1;
	localparam int ND    = (OW + 15) / 16;
	localparam int MPW   = ND * 16;
	localparam int DGW   = (ND > 1) ? $clog2(ND) : 1;
	localparam int BW    = OW + 2;
	localparam int SUMW  = (CW + 2 > 36) ? CW + 2 : 36;
	localparam int WORDW = 3 * CW + 3 * ExtW + 2;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_FETCH = 4'd1;
	localparam logic [3:0] S_CLASS = 4'd2;
	localparam logic [3:0] S_SQLD  = 4'd3;
	localparam logic [3:0] S_SQ    = 4'd4;
	localparam logic [3:0] S_BOX   = 4'd5;
	localparam logic [3:0] S_NEXT  = 4'd6;
	localparam logic [3:0] S_ROOT  = 4'd7;
	localparam logic [3:0] S_ROOTW = 4'd8;
	localparam logic [3:0] S_DIV   = 4'd9;
	localparam logic [3:0] S_DIVW  = 4'd10;
	localparam logic [3:0] S_MUL   = 4'd11;
	localparam logic [3:0] S_SUM   = 4'd12;
	localparam logic [3:0] S_DONE  = 4'd13;

	logic [3:0]      state_q;
	logic [CNTW-1:0] a_cnt_q, b_cnt_q;
	logic [IW-1:0]   ai_q, bj_q;
	logic [1:0]      k_q, kx;
	logic [DGW-1:0]  dg_q;
	logic            any_q, out_valid_q;

	logic [WORDW-1:0] mem_a [MAX_PRIMS];
	logic [WORDW-1:0] mem_b [MAX_PRIMS];
	logic [WORDW-1:0] rd_a_q, rd_b_q, wr_word;

	logic [OW-1:0]          m_q;
	logic signed [ACCW-1:0] acc_q, acc_next;
	logic [SW-1:0]          sumsq_q;
	logic [RW-1:0]          d_q;
	logic signed [NormW-1:0] n_q;
	logic signed [49:0]     prod2_q;

	// Working result and output registers
	logic                    w_found;
	logic [3:0]              w_ia, w_ib;
	logic signed [NormW-1:0] w_nrm [3];
	logic [30:0]             w_depth;
	logic signed [31:0]      w_cp [3];
	logic                    o_any, o_found;
	logic [3:0]              o_ia, o_ib;
	logic signed [NormW-1:0] o_nrm [3];
	logic [30:0]             o_depth;
	logic signed [31:0]      o_cp [3];

	logic accept, wr_a, wr_b;
	rd_ctrl_t rd_ctrl;
	rd_stat_t rd_stat;
	logic [RW-1:0] rd_result;

	// Field taps of the two fetched entries
	logic signed [CW-1:0] pa, pb;
	logic [ExtW-1:0]      ha, hb, ra, rb;
	logic [1:0]           shp_a, shp_b;
	logic signed [CW:0]   dif;
	logic [CW:0]          mag;
	logic [ExtW:0]        rsum;

	assign kx    = (k_q == 2'd3) ? 2'd0 : k_q;
	assign pa    = $signed(rd_a_q[kx*CW +: CW]);
	assign pb    = $signed(rd_b_q[kx*CW +: CW]);
	assign ha    = rd_a_q[3*CW + kx*ExtW +: ExtW];
	assign hb    = rd_b_q[3*CW + kx*ExtW +: ExtW];
	assign ra    = rd_a_q[3*CW +: ExtW];
	assign rb    = rd_b_q[3*CW +: ExtW];
	assign shp_a = rd_a_q[3*CW + 3*ExtW +: 2];
	assign shp_b = rd_b_q[3*CW + 3*ExtW +: 2];
	assign dif   = {pa[CW-1], pa} - {pb[CW-1], pb};
	assign mag   = dif[CW] ? (~dif + 1'b1) : dif;
	assign rsum  = {1'b0, ra} + {1'b0, rb};

	// Handshake and store writes
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign wr_a = accept && req.opcode == OP_LOAD_A && a_cnt_q < CNTW'(MAX_PRIMS);
	assign wr_b = accept && req.opcode == OP_LOAD_B && b_cnt_q < CNTW'(MAX_PRIMS);
	assign wr_word = {req.shape, req.extent_z, req.extent_y, req.extent_x,
		CW'(req.pos_z), CW'(req.pos_y), CW'(req.pos_x)};

	always_ff @(posedge clk) begin
		if (wr_a)
			mem_a[a_cnt_q[IW-1:0]] <= wr_word;
		if (wr_b)
			mem_b[b_cnt_q[IW-1:0]] <= wr_word;
		rd_a_q <= mem_a[ai_q];
		rd_b_q <= mem_b[bj_q];
	end

	// Shared multiply-accumulate: one 16-bit digit of the operand a cycle
	logic [MPW-1:0]   mpad;
	logic [15:0]      digit;
	logic [OW+15:0]   prod;
	logic [ACCW-1:0]  pshift;
	logic             last_dg, sep;
	always_comb begin
		mpad     = MPW'(m_q);
		digit    = mpad[dg_q*16 +: 16];
		prod     = m_q * digit;
		pshift   = ACCW'(prod) << {dg_q, 4'b0000};
		acc_next = (k_q == 2'd3) ? acc_q - $signed(pshift) : acc_q + $signed(pshift);
		last_dg  = (dg_q == DGW'(ND - 1));
	end

	// Box interval test on one axis
	logic signed [BW-1:0] pae, pbe, hae, hbe;
	always_comb begin
		pae = BW'(pa);
		pbe = BW'(pb);
		hae = BW'(ha);
		hbe = BW'(hb);
		sep = (pae - hae > pbe + hbe) || (pae + hae < pbe - hbe);
	end

	// Contact point on one axis: centre sum plus scaled normal, halved and saturated
	logic signed [33:0]     t_val;
	logic signed [SUMW-1:0] s_val, half;
	logic [31:0]            cp_val;
	always_comb begin
		t_val = 34'(prod2_q >>> 16);
		s_val = SUMW'(pa) + SUMW'(pb) + SUMW'(t_val);
		half  = s_val >>> 1;
		if (half[SUMW-1:31] == '0 || half[SUMW-1:31] == '1)
			cp_val = half[31:0];
		else
			cp_val = half[SUMW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	end

	logic signed [31:0] drr;
	assign drr = $signed({2'b00, rb}) - $signed({2'b00, ra});

	// Root and divide unit
	assign rd_ctrl.start  = (state_q == S_ROOT) || (state_q == S_DIV && d_q != '0);
	assign rd_ctrl.is_div = (state_q == S_DIV);

	psct_rootdiv #(.RW(RW)) u_rootdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (rd_ctrl),
		.radicand (sumsq_q),
		.dividend (OW'(mag)),
		.divisor  (d_q),
		.stat     (rd_stat),
		.result   (rd_result)
	);

	// Pair scan sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			a_cnt_q <= '0;
			b_cnt_q <= '0;
			ai_q    <= '0;
			bj_q    <= '0;
			k_q     <= '0;
			dg_q    <= '0;
			any_q   <= 1'b0;
			w_found <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.opcode)
							OP_CLEAR: begin
								a_cnt_q <= '0;
								b_cnt_q <= '0;
							end
							OP_LOAD_A: begin
								if (wr_a)
									a_cnt_q <= a_cnt_q + 1'b1;
							end
							OP_LOAD_B: begin
								if (wr_b)
									b_cnt_q <= b_cnt_q + 1'b1;
							end
							OP_QUERY: begin
								ai_q    <= '0;
								bj_q    <= '0;
								any_q   <= 1'b0;
								w_found <= 1'b0;
								if (a_cnt_q == '0 || b_cnt_q == '0)
									state_q <= S_DONE;
								else
									state_q <= S_FETCH;
							end
							default: begin
							end
						endcase
					end
				end
				S_FETCH: state_q <= S_CLASS;
				S_CLASS: begin
					k_q  <= '0;
					dg_q <= '0;
					if (shp_a == SHAPE_SPHERE && shp_b == SHAPE_SPHERE)
						state_q <= S_SQLD;
					else if (shp_a == SHAPE_BOX && shp_b == SHAPE_BOX)
						state_q <= S_BOX;
					else
						state_q <= S_NEXT;
				end
				S_SQLD: state_q <= S_SQ;
				S_SQ: begin
					if (last_dg) begin
						dg_q <= '0;
						if (k_q == 2'd3) begin
							if (acc_next[ACCW-1] || acc_next == '0) begin
								any_q   <= 1'b1;
								state_q <= S_ROOT;
							end else begin
								state_q <= S_NEXT;
							end
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_SQLD;
						end
					end else begin
						dg_q <= dg_q + 1'b1;
					end
				end
				S_BOX: begin
					if (sep) begin
						state_q <= S_NEXT;
					end else if (k_q == 2'd2) begin
						any_q   <= 1'b1;
						state_q <= S_NEXT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_NEXT: begin
					if (CNTW'(bj_q) + 1'b1 < b_cnt_q) begin
						bj_q    <= bj_q + 1'b1;
						state_q <= S_FETCH;
					end else if (CNTW'(ai_q) + 1'b1 < a_cnt_q) begin
						ai_q    <= ai_q + 1'b1;
						bj_q    <= '0;
						state_q <= S_FETCH;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_ROOT: state_q <= S_ROOTW;
				S_ROOTW: begin
					if (rd_stat.done) begin
						k_q     <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: state_q <= (d_q == '0) ? S_MUL : S_DIVW;
				S_DIVW: begin
					if (rd_stat.done)
						state_q <= S_MUL;
				end
				S_MUL: state_q <= S_SUM;
				S_SUM: begin
					if (k_q == 2'd2) begin
						w_found <= 1'b1;
						state_q <= S_DONE;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_DIV;
					end
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Arithmetic and working result registers
	always_ff @(posedge clk) begin
		if (accept && req.opcode == OP_QUERY) begin
			w_ia    <= '0;
			w_ib    <= '0;
			w_depth <= '0;
			for (int i = 0; i < 3; i++) begin
				w_nrm[i] <= '0;
				w_cp[i]  <= '0;
			end
		end
		if (state_q == S_CLASS)
			acc_q <= '0;
		if (state_q == S_SQLD)
			m_q <= (k_q == 2'd3) ? OW'(rsum) : OW'(mag);
		if (state_q == S_SQ) begin
			acc_q <= acc_next;
			if (last_dg && k_q == 2'd2)
				sumsq_q <= acc_next[SW-1:0];
		end
		if (state_q == S_ROOTW && rd_stat.done) begin
			d_q     <= rd_result;
			w_depth <= 31'(RW'(rsum) - rd_result);
			w_ia    <= 4'(ai_q);
			w_ib    <= 4'(bj_q);
		end
		if (state_q == S_DIV && d_q == '0)
			n_q <= '0;
		if (state_q == S_DIVW && rd_stat.done) begin
			if (dif[CW])
				n_q <= ~rd_result[NormW-1:0] + 1'b1;
			else
				n_q <= rd_result[NormW-1:0];
		end
		if (state_q == S_MUL) begin
			prod2_q   <= n_q * drr;
			w_nrm[kx] <= n_q;
		end
		if (state_q == S_SUM)
			w_cp[kx] <= cp_val;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == S_DONE && (!out_valid_q || rsp.ready))
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || rsp.ready)) begin
			o_any   <= any_q;
			o_found <= w_found;
			o_ia    <= w_ia;
			o_ib    <= w_ib;
			o_depth <= w_depth;
			for (int i = 0; i < 3; i++) begin
				o_nrm[i] <= w_nrm[i];
				o_cp[i]  <= w_cp[i];
			end
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.any_overlap   = o_any;
	assign rsp.contact_found = o_found;
	assign rsp.index_a       = o_ia;
	assign rsp.index_b       = o_ib;
	assign rsp.normal_x      = o_nrm[0];
	assign rsp.normal_y      = o_nrm[1];
	assign rsp.normal_z      = o_nrm[2];
	assign rsp.depth         = o_depth;
	assign rsp.contact_x     = o_cp[0];
	assign rsp.contact_y     = o_cp[1];
	assign rsp.contact_z     = o_cp[2];

`ifndef ASSERT_OFF
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		a_cnt_q <= CNTW'(MAX_PRIMS) && b_cnt_q <= CNTW'(MAX_PRIMS))
		else $error("set count beyond capacity");
	a_contact_any: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && o_found |-> o_any) else $error("contact without overlap");
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rd_stat.done |-> (state_q == S_ROOTW || state_q == S_DIVW))
		else $error("root unit finished outside a wait state");
	a_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		rd_ctrl.start |-> !rd_stat.busy) else $error("root unit started while busy");
`endif

endmodule

// ===== tb/primitive_set_collision_test_top_test.sv =====
// Self-checking testbench for the primitive set collision test block.
module primitive_set_collision_test_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import psct_pkg::*;

	typedef struct {
		logic [1:0]         opcode;
		logic [1:0]         shape;
		logic signed [31:0] pos [3];
		logic [29:0]        ext [3];
	} shape_item_t;

	typedef struct {
		logic               any_overlap;
		logic               contact_found;
		logic [3:0]         index_a;
		logic [3:0]         index_b;
		logic signed [17:0] normal [3];
		logic [30:0]        depth;
		logic signed [31:0] contact [3];
	} query_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	psct_req_if req ();
	psct_rsp_if rsp ();

	primitive_set_collision_test_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	// Shape stores of the predictor
	int unsigned        set_count [2];
	logic [1:0]         set_shape [2][MaxPrims];
	logic signed [63:0] set_pos   [2][MaxPrims][3];
	logic [29:0]        set_ext   [2][MaxPrims][3];

	shape_item_t   pending_items [$];
	query_result_t expected_results [$];
	shape_item_t   driven_item;
	int unsigned   items_sent = 0;
	int unsigned   total_items = 0;
	int unsigned   queries_checked = 0;
	int unsigned   contacts_seen = 0;
	int unsigned   mismatches = 0;
	bit            stim_done = 1'b0;

	// Square of a centre-distance, summed over the axes
	function automatic logic [127:0] dist_sq(int unsigned i, int unsigned j);
		logic [127:0] acc;
		logic signed [63:0] dv;
		logic [63:0] m;
		acc = '0;
		for (int k = 0; k < 3; k++) begin
			dv = set_pos[0][i][k] - set_pos[1][j][k];
			m = dv < 0 ? -dv : dv;
			acc += 128'(m) * 128'(m);
		end
		return acc;
	endfunction

	function automatic bit pair_overlaps(int unsigned i, int unsigned j);
		logic [127:0] r;
		logic signed [63:0] pa, pb, ha, hb;
		if (set_shape[0][i] == SHAPE_SPHERE && set_shape[1][j] == SHAPE_SPHERE) begin
			r = 128'(set_ext[0][i][0]) + 128'(set_ext[1][j][0]);
			return dist_sq(i, j) <= r * r;
		end
		if (set_shape[0][i] == SHAPE_BOX && set_shape[1][j] == SHAPE_BOX) begin
			for (int k = 0; k < 3; k++) begin
				pa = set_pos[0][i][k];
				pb = set_pos[1][j][k];
				ha = 64'(set_ext[0][i][k]);
				hb = 64'(set_ext[1][j][k]);
				if (pa - ha > pb + hb || pa + ha < pb - hb)
					return 1'b0;
			end
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Normal, depth and surface midpoint of one sphere pair
	function automatic void sphere_contact(int unsigned i, int unsigned j,
			ref query_result_t res);
		logic [127:0] n2, num, c;
		logic [63:0] d, q, m, ra, rb;
		logic signed [63:0] dv, nk, t, s;
		n2 = dist_sq(i, j);
		d = '0;
		for (int b = 63; b >= 0; b--) begin
			c = 128'(d | (64'd1 << b));
			if (c * c <= n2)
				d = c[63:0];
		end
		ra = 64'(set_ext[0][i][0]);
		rb = 64'(set_ext[1][j][0]);
		for (int k = 0; k < 3; k++) begin
			dv = set_pos[0][i][k] - set_pos[1][j][k];
			m = dv < 0 ? -dv : dv;
			q = '0;
			if (d != 0) begin
				num = 128'(m) << 16;
				for (int b = 17; b >= 0; b--)
					if (128'(q | (64'd1 << b)) * 128'(d) <= num)
						q = q | (64'd1 << b);
			end
			nk = dv < 0 ? -$signed(q) : $signed(q);
			res.normal[k] = nk[17:0];
			t = (nk * ($signed(rb) - $signed(ra))) >>> 16;
			s = (set_pos[0][i][k] + set_pos[1][j][k] + t) >>> 1;
			if (s > 64'sd2147483647)
				s = 64'sd2147483647;
			else if (s < -64'sd2147483648)
				s = -64'sd2147483648;
			res.contact[k] = s[31:0];
		end
		res.depth = 31'(ra + rb - d);
		res.contact_found = 1'b1;
		res.index_a = i[3:0];
		res.index_b = j[3:0];
	endfunction

	// Apply one accepted item to the predictor state
	function automatic void apply_item(shape_item_t it);
		query_result_t res;
		int unsigned s;
		case (it.opcode)
			OP_CLEAR: begin
				set_count[0] = 0;
				set_count[1] = 0;
			end
			OP_LOAD_A, OP_LOAD_B: begin
				s = (it.opcode == OP_LOAD_A) ? 0 : 1;
				if (set_count[s] < MaxPrims) begin
					set_shape[s][set_count[s]] = it.shape;
					for (int k = 0; k < 3; k++) begin
						set_pos[s][set_count[s]][k] = 64'(it.pos[k]);
						set_ext[s][set_count[s]][k] = it.ext[k];
					end
					set_count[s]++;
				end
			end
			default: begin
				res.any_overlap = 1'b0;
				res.contact_found = 1'b0;
				res.index_a = '0;
				res.index_b = '0;
				res.depth = '0;
				for (int k = 0; k < 3; k++) begin
					res.normal[k] = '0;
					res.contact[k] = '0;
				end
				for (int i = 0; i < set_count[0]; i++)
					for (int j = 0; j < set_count[1]; j++)
						if (pair_overlaps(i, j)) begin
							res.any_overlap = 1'b1;
							if (!res.contact_found && set_shape[0][i] == SHAPE_SPHERE &&
									set_shape[1][j] == SHAPE_SPHERE)
								sphere_contact(i, j, res);
						end
				expected_results.insert(expected_results.size(), res);
			end
		endcase
	endfunction

	// Idle and stall rates by phase of the run
	function automatic bit idle_now(bit is_sender);
		int unsigned phase;
		int unsigned pct;
		phase = total_items == 0 ? 0 : (items_sent * 4) / total_items;
		case (phase)
			0: pct = 0;
			1: pct = is_sender ? 83 : 0;
			2: pct = is_sender ? 0 : 83;
			default: pct = 9;
		endcase
		return $urandom_range(99) < pct;
	endfunction

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.opcode <= OP_CLEAR;
			req.shape <= SHAPE_NONE;
			req.pos_x <= '0;
			req.pos_y <= '0;
			req.pos_z <= '0;
			req.extent_x <= '0;
			req.extent_y <= '0;
			req.extent_z <= '0;
		end else begin
			if (req.valid && req.ready) begin
				apply_item(driven_item);
				items_sent++;
			end
			if (!req.valid || req.ready) begin
				if (pending_items.size() > 0 && !idle_now(1'b1)) begin
					driven_item = pending_items.pop_front();
					req.valid <= 1'b1;
					req.opcode <= driven_item.opcode;
					req.shape <= driven_item.shape;
					req.pos_x <= driven_item.pos[0];
					req.pos_y <= driven_item.pos[1];
					req.pos_z <= driven_item.pos[2];
					req.extent_x <= driven_item.ext[0];
					req.extent_y <= driven_item.ext[1];
					req.extent_z <= driven_item.ext[2];
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and checker
	always @(posedge clk or negedge arst_n) begin
		query_result_t exp_res;
		bit bad;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: result with no query outstanding");
				end else begin
					exp_res = expected_results.pop_front();
					queries_checked++;
					if (exp_res.contact_found)
						contacts_seen++;
					bad = rsp.any_overlap !== exp_res.any_overlap ||
						rsp.contact_found !== exp_res.contact_found ||
						rsp.index_a !== exp_res.index_a ||
						rsp.index_b !== exp_res.index_b ||
						rsp.normal_x !== exp_res.normal[0] ||
						rsp.normal_y !== exp_res.normal[1] ||
						rsp.normal_z !== exp_res.normal[2] ||
						rsp.depth !== exp_res.depth ||
						rsp.contact_x !== exp_res.contact[0] ||
						rsp.contact_y !== exp_res.contact[1] ||
						rsp.contact_z !== exp_res.contact[2];
					if (bad) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"ERROR: query %0d exp ov=%b cf=%b ia=%0d ib=%0d ",
								"n=%0d,%0d,%0d dp=%0d c=%0d,%0d,%0d got ov=%b cf=%b ",
								"ia=%0d ib=%0d n=%0d,%0d,%0d dp=%0d c=%0d,%0d,%0d"},
								queries_checked, exp_res.any_overlap,
								exp_res.contact_found, exp_res.index_a, exp_res.index_b,
								exp_res.normal[0], exp_res.normal[1], exp_res.normal[2],
								exp_res.depth, exp_res.contact[0], exp_res.contact[1],
								exp_res.contact[2], rsp.any_overlap, rsp.contact_found,
								rsp.index_a, rsp.index_b, rsp.normal_x, rsp.normal_y,
								rsp.normal_z, rsp.depth, rsp.contact_x, rsp.contact_y,
								rsp.contact_z);
					end
				end
			end
			rsp.ready <= !idle_now(1'b0);
		end
	end

	function automatic shape_item_t make_item(logic [1:0] op, logic [1:0] sh,
			int px, int py, int pz, int ex, int ey, int ez);
		shape_item_t it;
		it.opcode = op;
		it.shape = sh;
		it.pos[0] = px;
		it.pos[1] = py;
		it.pos[2] = pz;
		it.ext[0] = ex[29:0];
		it.ext[1] = ey[29:0];
		it.ext[2] = ez[29:0];
		return it;
	endfunction

	// Random shape, either anywhere or near a shared centre so pairs meet
	function automatic shape_item_t rand_shape(logic [1:0] op, logic signed [31:0] base[3]);
		shape_item_t it;
		int unsigned pick;
		it.opcode = op;
		pick = $urandom_range(99);
		it.shape = pick < 45 ? SHAPE_SPHERE : pick < 85 ? SHAPE_BOX :
			pick < 93 ? SHAPE_NONE : 2'd3;
		for (int k = 0; k < 3; k++) begin
			if ($urandom_range(9) == 0)
				it.pos[k] = $urandom;
			else
				it.pos[k] = base[k] + $signed($urandom_range(32'h0004_0000)) -
					32'sh0002_0000;
			if ($urandom_range(9) == 0)
				it.ext[k] = 30'($urandom);
			else
				it.ext[k] = 30'($urandom_range(32'h0003_0000));
		end
		return it;
	endfunction

	task automatic push(shape_item_t it);
		pending_items.insert(pending_items.size(), it);
		total_items++;
	endtask

	// Stimulus
	initial begin
		logic signed [31:0] base [3];
		int unsigned na, nb;
		set_count[0] = 0;
		set_count[1] = 0;

		// Directed: empty query, coincident spheres, extremes, odd shapes, full set
		push(make_item(OP_QUERY, SHAPE_NONE, 0, 0, 0, 0, 0, 0));
		push(make_item(OP_LOAD_A, SHAPE_SPHERE, 0, 0, 0, 32'h10000, 0, 0));
		push(make_item(OP_LOAD_B, SHAPE_SPHERE, 0, 0, 0, 32'h20000, 0, 0));
		push(make_item(OP_QUERY, SHAPE_NONE, 0, 0, 0, 0, 0, 0));
		push(make_item(OP_CLEAR, SHAPE_NONE, -1, -1, -1, -1, -1, -1));
		push(make_item(OP_LOAD_A, SHAPE_SPHERE, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h3fffffff, 0, 0));
		push(make_item(OP_LOAD_B, SHAPE_SPHERE, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h3fffffff, 32'h3fffffff, 32'h3fffffff));
		push(make_item(OP_LOAD_A, SHAPE_BOX, 32'h7fffffff, 32'h80000000, 0,
			32'h3fffffff, 32'h3fffffff, 32'h3fffffff));
		push(make_item(OP_LOAD_B, SHAPE_BOX, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0));
		push(make_item(OP_LOAD_A, 2'd3, 0, 0, 0, 32'h1000, 32'h1000, 32'h1000));
		push(make_item(OP_LOAD_B, SHAPE_NONE, 0, 0, 0, 32'h1000, 32'h1000, 32'h1000));
		push(make_item(OP_LOAD_B, SHAPE_SPHERE, 32'h30000, -32'h40000, 32'h50000,
			32'h70000, 0, 0));
		push(make_item(OP_QUERY, SHAPE_NONE, 0, 0, 0, 0, 0, 0));
		push(make_item(OP_CLEAR, SHAPE_NONE, 0, 0, 0, 0, 0, 0));
		for (int n = 0; n < MaxPrims + 1; n++)
			push(make_item(OP_LOAD_A, SHAPE_BOX, n << 16, 0, 0, 32'h8000, 32'h8000, 32'h8000));
		push(make_item(OP_LOAD_B, SHAPE_BOX, 32'h0f8000, 0, 0, 32'h8000, 32'h8000, 32'h8000));
		push(make_item(OP_QUERY, SHAPE_NONE, 0, 0, 0, 0, 0, 0));
		push(make_item(OP_CLEAR, SHAPE_NONE, 0, 0, 0, 0, 0, 0));
		push(make_item(OP_QUERY, SHAPE_NONE, 0, 0, 0, 0, 0, 0));

		// Random: mostly clear, load both sets, query; some noise and full sets
		while (total_items < 650) begin
			for (int k = 0; k < 3; k++)
				base[k] = $urandom;
			if ($urandom_range(9) != 0)
				push(make_item(OP_CLEAR, 2'($urandom), $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom));
			na = $urandom_range(19) == 0 ? MaxPrims + 1 : $urandom_range(1, 4);
			nb = $urandom_range(19) == 0 ? MaxPrims + 1 : $urandom_range(1, 4);
			for (int n = 0; n < na; n++)
				push(rand_shape(OP_LOAD_A, base));
			for (int n = 0; n < nb; n++)
				push(rand_shape(OP_LOAD_B, base));
			push(make_item(OP_QUERY, 2'($urandom), $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom));
			if ($urandom_range(3) == 0)
				push(make_item(OP_QUERY, SHAPE_NONE, 0, 0, 0, 0, 0, 0));
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_items.size() == 0 && items_sent == total_items &&
			expected_results.size() == 0);
		repeat (100) @(posedge clk);
		stim_done = 1'b1;
		$display("Ran %0d items, %0d queries checked, %0d with a sphere contact.",
			items_sent, queries_checked, contacts_seen);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("primitive_set_collision_test_top verification clean");
		else
			$display("primitive_set_collision_test_top verification failed");
		$finish;
	end

	// Watchdog
	initial begin
		#100ms;
		if (!stim_done) begin
			$display("ERROR: timeout, %0d items sent, %0d results outstanding",
				items_sent, expected_results.size());
			$display("primitive_set_collision_test_top verification failed");
			$finish;
		end
	end
endmodule

// ===== filelist.f =====
design/psct_pkg.sv
design/psct_if.sv
design/psct_rootdiv.sv
design/primitive_set_collision_test_top.sv
tb/primitive_set_collision_test_top_test.sv
